### rtl/core/double_ended_queue_with_search_macros.svh
// Assertion macros for the double-ended queue block
`ifndef DOUBLE_ENDED_QUEUE_WITH_SEARCH_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_WITH_SEARCH_MACROS_SVH

`ifndef ASSERT_OFF
`define DEQ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define DEQ_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define DEQ_ASSERT(lbl, clk, rst, prop, msg)
`define DEQ_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`endif

`endif

### rtl/core/deq_pkg.sv
// Shared types, request codes and defaults for the double-ended queue
`default_nettype none
package deq_pkg;

  localparam int DEQ_DEPTH  = 16;
  localparam int DEQ_DATA_W = 32;

  localparam int REQ_W  = 4;
  localparam int WORD_W = 32;
  localparam int TOT_W  = 5;

  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 4'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 4'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 4'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 4'd3;
  localparam logic [REQ_W-1:0] REQ_PEEK_FRONT = 4'd4;
  localparam logic [REQ_W-1:0] REQ_PEEK_BACK  = 4'd5;
  localparam logic [REQ_W-1:0] REQ_FIND       = 4'd6;
  localparam logic [REQ_W-1:0] REQ_REMOVE     = 4'd7;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } deq_status_t;

  typedef enum logic [1:0] {
    SEL_ZERO  = 2'd0,
    SEL_RDATA = 2'd1,
    SEL_FOUND = 2'd2
  } deq_sel_t;

  typedef struct packed {
    logic        latch;
    logic        push_do;
    logic        rd_end;
    logic        end_upd;
    logic        scan_start;
    logic        step;
    logic        shift_wr;
    logic        found_ld;
    logic        match_rm;
    logic        rm_done;
    logic        out_load;
    deq_status_t res_status;
    deq_sel_t    res_sel;
  } deq_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             empty;
    logic             full;
    logic             match;
    logic             miss_last;
    logic             more;
    logic             pvalid;
    logic             out_busy;
  } deq_stat_t;

endpackage
`default_nettype wire

### rtl/core/deq_ctrl.sv
// Request sequencer: decodes each request and steps the datapath through it
`default_nettype none
module deq_ctrl import deq_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_tvalid,
  output logic           s_tready,
  input  wire deq_stat_t stat,
  output deq_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t      state, state_next;
  deq_status_t res_status, res_status_next;
  deq_sel_t    res_sel, res_sel_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.res_status = res_status;
    cmd.res_sel = res_sel;
    state_next = state;
    res_status_next = res_status;
    res_sel_next = res_sel;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.latch = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        res_status_next = ST_OK;
        res_sel_next = SEL_ZERO;
        state_next = S_DONE;
        if (stat.req inside {REQ_PUSH_FRONT, REQ_PUSH_BACK}) begin
          if (stat.full) begin
            res_status_next = ST_FULL;
          end else begin
            cmd.push_do = 1'b1;
          end
        end else if (stat.req inside {REQ_POP_FRONT, REQ_POP_BACK,
                                      REQ_PEEK_FRONT, REQ_PEEK_BACK}) begin
          if (stat.empty) begin
            res_status_next = ST_EMPTY;
          end else begin
            cmd.rd_end = 1'b1;
            state_next = S_RDWAIT;
          end
        end else if (stat.req inside {REQ_FIND, REQ_REMOVE}) begin
          if (stat.empty) begin
            res_status_next = ST_NOTFOUND;
          end else begin
            cmd.scan_start = 1'b1;
            state_next = S_SCAN;
          end
        end
      end
      S_RDWAIT: begin
        cmd.end_upd = 1'b1;
        res_status_next = ST_OK;
        res_sel_next = SEL_RDATA;
        state_next = S_DONE;
      end
      S_SCAN: begin
        if (stat.match) begin
          cmd.found_ld = 1'b1;
          res_status_next = ST_OK;
          res_sel_next = SEL_FOUND;
          if (stat.req == REQ_REMOVE) begin
            cmd.match_rm = 1'b1;
            state_next = S_SHIFT;
          end else begin
            state_next = S_DONE;
          end
        end else if (stat.miss_last) begin
          res_status_next = ST_NOTFOUND;
          res_sel_next = SEL_ZERO;
          state_next = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_SHIFT: begin
        if (!stat.more && !stat.pvalid) begin
          cmd.rm_done = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.step = 1'b1;
          cmd.shift_wr = 1'b1;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_status <= ST_OK;
      res_sel <= SEL_ZERO;
    end else begin
      state <= state_next;
      res_status <= res_status_next;
      res_sel <= res_sel_next;
    end
  end

endmodule
`default_nettype wire

### rtl/core/deq_dp.sv
// Datapath: ring store, front and count, scan and shift indexes, result register
`default_nettype none
`include "double_ended_queue_with_search_macros.svh"
module deq_dp import deq_pkg::*; #(
  parameter int DEPTH  = DEQ_DEPTH,
  parameter int DATA_W = DEQ_DATA_W
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [REQ_W-1:0]  in_req,
  input  wire logic [WORD_W-1:0] in_word,
  input  wire deq_cmd_t          cmd,
  output deq_stat_t              stat,
  input  wire logic              m_tready,
  output logic                   o_valid,
  output deq_status_t            o_status,
  output logic [WORD_W-1:0]      o_data,
  output logic [TOT_W-1:0]       o_total
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata;
  logic [DATA_W-1:0] found;
  logic [DATA_W-1:0] key;
  logic [REQ_W-1:0]  req;
  logic [AW-1:0]     front;
  logic [CW-1:0]     count;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     pidx;
  logic              pvalid;

  logic [63:0]       word_ext;
  logic [SW-1:0]     front_ext;
  logic [AW-1:0]     a_front_m1, a_front_p1, a_back, a_last, a_idx, a_shift;
  logic              rd_en, we, more, match_raw, at_front;
  logic [AW-1:0]     raddr, waddr;
  logic [DATA_W-1:0] wdata;
  logic [DATA_W-1:0] sel_word;
  logic [63:0]       sel_ext;
  logic [SW-1:0]     count_ext;

  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] sum);
    logic [SW-1:0] fixed;
    fixed = (sum >= SW'(DEPTH)) ? (sum - SW'(DEPTH)) : sum;
    return fixed[AW-1:0];
  endfunction

  assign word_ext   = 64'(in_word);
  assign front_ext  = SW'(front);
  assign a_front_m1 = (front == '0) ? AW'(DEPTH - 1) : front - AW'(1);
  assign a_front_p1 = (front == AW'(DEPTH - 1)) ? '0 : front + AW'(1);
  assign a_back     = wrap(front_ext + SW'(count));
  assign a_last     = wrap(front_ext + SW'(count) - SW'(1));
  assign a_idx      = wrap(front_ext + SW'(idx));
  assign a_shift    = wrap(front_ext + SW'(pidx) - SW'(1));

  assign more      = (idx < count);
  assign match_raw = (rdata == key);
  assign at_front  = (req == REQ_POP_FRONT) || (req == REQ_PEEK_FRONT);

  assign rd_en = cmd.rd_end || (cmd.step && more);
  assign raddr = cmd.rd_end ? (at_front ? front : a_last) : a_idx;
  assign we    = cmd.push_do || (cmd.shift_wr && pvalid);
  assign waddr = cmd.push_do ? ((req == REQ_PUSH_FRONT) ? a_front_m1 : a_back) : a_shift;
  assign wdata = cmd.push_do ? key : rdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req <= in_req;
      key <= word_ext[DATA_W-1:0];
    end
    if (cmd.found_ld) begin
      found <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
      idx <= '0;
      pidx <= '0;
      pvalid <= 1'b0;
    end else begin
      if (cmd.push_do) begin
        count <= count + CW'(1);
        if (req == REQ_PUSH_FRONT) begin
          front <= a_front_m1;
        end
      end
      if (cmd.end_upd) begin
        if (req == REQ_POP_FRONT) begin
          front <= a_front_p1;
          count <= count - CW'(1);
        end else if (req == REQ_POP_BACK) begin
          count <= count - CW'(1);
        end
      end
      if (cmd.rm_done) begin
        count <= count - CW'(1);
      end
      if (cmd.scan_start) begin
        idx <= '0;
        pvalid <= 1'b0;
      end else if (cmd.match_rm) begin
        idx <= pidx + CW'(1);
        pvalid <= 1'b0;
      end else if (cmd.step) begin
        pvalid <= more;
        pidx <= idx;
        if (more) begin
          idx <= idx + CW'(1);
        end
      end
    end
  end

  always_comb begin
    case (cmd.res_sel)
      SEL_RDATA: sel_word = rdata;
      SEL_FOUND: sel_word = found;
      default:   sel_word = '0;
    endcase
  end

  assign sel_ext = 64'(sel_word);
  assign count_ext = SW'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (cmd.out_load) begin
      o_valid <= 1'b1;
    end else if (m_tready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_status <= cmd.res_status;
      o_data <= sel_ext[WORD_W-1:0];
      o_total <= TOT_W'(count_ext);
    end
  end

  always_comb begin
    stat.req = req;
    stat.empty = (count == '0);
    stat.full = (count >= CW'(DEPTH));
    stat.match = pvalid && match_raw;
    stat.miss_last = pvalid && !match_raw && (pidx == count - CW'(1));
    stat.more = more;
    stat.pvalid = pvalid;
    stat.out_busy = o_valid && !m_tready;
  end

  `DEQ_ASSERT(a_count_max, clk, rst, count <= CW'(DEPTH), "entry count above depth")
  `DEQ_ASSERT_IMP(a_push_room, clk, rst, cmd.push_do, count < CW'(DEPTH), "push with no room")
  `DEQ_ASSERT_IMP(a_load_free, clk, rst, cmd.out_load, !(o_valid && !m_tready), "result overrun")
  `DEQ_ASSERT_IMP(a_shift_idx, clk, rst, cmd.shift_wr && pvalid, pidx != '0, "shift below front")

endmodule
`default_nettype wire

### rtl/core/double_ended_queue_with_search.sv
// Top level of the double-ended queue with search
// One request at a time. A push, unused code or failed request goes from decode
// straight to the result, and a pop or peek first reads its end of the store. Find
// and remove read the store one entry per cycle from the front and stop at the
// first match or after the last entry; a remove then shifts the later entries one
// per cycle through the one read port and one write port to close the gap. The
// result sits in an output register, so the next request is taken while it waits;
// a stalled result blocks only the finish of the next request.
`default_nettype none
module double_ended_queue_with_search import deq_pkg::*; #(
  parameter int DEPTH  = DEQ_DEPTH,
  parameter int DATA_W = DEQ_DATA_W
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // item_value[31:0]
  input  wire logic [3:0]  s_tuser,   // req_type[3:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // data_out[31:0], entry_total[36:32], zero[39:37]
  output logic [1:0]       m_tuser    // status[1:0]
);

  deq_cmd_t          cmd;
  deq_stat_t         stat;
  deq_status_t       o_status;
  logic [WORD_W-1:0] o_data;
  logic [TOT_W-1:0]  o_total;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  deq_dp #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_req   (s_tuser),
    .in_word  (s_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .m_tready (m_tready),
    .o_valid  (m_tvalid),
    .o_status (o_status),
    .o_data   (o_data),
    .o_total  (o_total)
  );

  assign m_tdata = {3'b000, o_total, o_data};
  assign m_tuser = o_status;

endmodule
`default_nettype wire
